// File: rtl/lfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar frame parser package
// Shared constants, event codes and the result record of the frame parser.
// ----------------------------------------------------------------------------
package lfp_pkg;

  localparam int FRAME_LENGTH = 9;
  localparam int POS_W        = $clog2(FRAME_LENGTH);
  localparam int DATA_BYTES   = FRAME_LENGTH - 2;
  localparam int FB_IDX_W     = $clog2(DATA_BYTES);
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 1;
  localparam int CNT_W        = 32;

  localparam logic [7:0]  HEADER_BYTE          = 8'h59;
  localparam logic [15:0] MIN_STRENGTH_RST     = 16'd100;
  localparam logic [15:0] INVALID_DISTANCE_RST = 16'hFFFF;

  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_STRENGTH     = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INVALID_DISTANCE = 1'd1;

  typedef enum logic [2:0] {
    EV_IN_FRAME,
    EV_VALID,
    EV_CHECKSUM,
    EV_WEAK,
    EV_BAD_HEADER,
    EV_DROPPED
  } event_t;

  typedef struct packed {
    event_t             event_res;
    logic signed [15:0] distance_cm;
    logic [15:0]        signal_strength;
    logic [15:0]        temp_centi;
    logic               reading_valid;
    logic [CNT_W-1:0]   good_frames;
    logic [CNT_W-1:0]   checksum_errors;
    logic [CNT_W-1:0]   weak_frames;
    logic [CNT_W-1:0]   dropped_bytes;
  } result_t;

endpackage

// File: rtl/lidar_frame_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar frame parser unit
// Byte-serial parser for 9-byte ranging-sensor frames with held readings
// and wrapping event counters.
// ----------------------------------------------------------------------------
// The unit takes one received byte per clock while in_stall is low and
// returns one registered result per byte. The parse state, held readings
// and counters are updated by a single stage of logic in the accepting
// cycle, so a new byte can be taken in every cycle that in_stall is low.
// Results sit in a two-entry output buffer: an output register and a skid
// register. in_stall rises only when the skid register holds a result,
// that is when a further byte arrived while the downstream side stalled
// the output register; at most two results are ever waiting.
module lidar_frame_parser_unit (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [lfp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lfp_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        rx_byte,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        event_res,
  output logic signed [15:0]                distance_cm,
  output logic [15:0]                       signal_strength,
  output logic [15:0]                       temp_centi,
  output logic                              reading_valid,
  output logic [lfp_pkg::CNT_W-1:0]         good_frames,
  output logic [lfp_pkg::CNT_W-1:0]         checksum_errors,
  output logic [lfp_pkg::CNT_W-1:0]         weak_frames,
  output logic [lfp_pkg::CNT_W-1:0]         dropped_bytes
);
  import lfp_pkg::*;

  // Configuration registers.
  logic [15:0] min_strength;
  logic [15:0] invalid_distance;

  // Parse state.
  logic [POS_W-1:0] frame_position, frame_position_next;
  logic [7:0]       byte_sum, byte_sum_next;
  logic [7:0]       frame_bytes [DATA_BYTES];
  logic [FB_IDX_W-1:0] fb_wr_idx;
  logic             fb_we;

  // Held readings and counters.
  logic [15:0]      held_distance, held_distance_next;
  logic [15:0]      held_strength, held_strength_next;
  logic [15:0]      held_temperature, held_temperature_next;
  logic [CNT_W-1:0] cnt_good, cnt_good_next;
  logic [CNT_W-1:0] cnt_checksum, cnt_checksum_next;
  logic [CNT_W-1:0] cnt_weak, cnt_weak_next;
  logic [CNT_W-1:0] cnt_dropped, cnt_dropped_next;

  // Frame fields, read at fixed places of the byte store.
  logic [15:0] frame_distance;
  logic [15:0] frame_strength;
  logic [15:0] frame_temperature;

  event_t  ev;
  result_t res_next;

  // Output buffer.
  result_t out_res, skid_res;
  logic    skid_valid;
  logic    in_fire, out_free;

  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !skid_valid;
  assign out_free = !out_valid || !out_stall;

  // Configuration writes. Changing the invalid marker does not touch the
  // held distance; only the comparison for reading_valid follows it.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_strength     <= MIN_STRENGTH_RST;
      invalid_distance <= INVALID_DISTANCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_STRENGTH:     min_strength     <= cfg_data;
        CFG_INVALID_DISTANCE: invalid_distance <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Store byte positions 1..7 of the frame; the second header byte lands
  // in entry zero. The ninth byte is the checksum and is compared directly.
  assign frame_distance    = {frame_bytes[2], frame_bytes[1]};
  assign frame_strength    = {frame_bytes[4], frame_bytes[3]};
  assign frame_temperature = {frame_bytes[6], frame_bytes[5]};
  assign fb_wr_idx         = FB_IDX_W'(frame_position - POS_W'(1));

  always_comb begin
    frame_position_next   = frame_position;
    byte_sum_next         = byte_sum;
    fb_we                 = 1'b0;
    held_distance_next    = held_distance;
    held_strength_next    = held_strength;
    held_temperature_next = held_temperature;
    cnt_good_next         = cnt_good;
    cnt_checksum_next     = cnt_checksum;
    cnt_weak_next         = cnt_weak;
    cnt_dropped_next      = cnt_dropped;
    ev                    = EV_IN_FRAME;

    if (frame_position == '0) begin
      // Hunting for the first header byte.
      if (rx_byte == HEADER_BYTE) begin
        byte_sum_next       = rx_byte;
        frame_position_next = POS_W'(1);
      end else begin
        cnt_dropped_next = cnt_dropped + CNT_W'(1);
        ev               = EV_DROPPED;
      end
    end else if (frame_position < POS_W'(FRAME_LENGTH - 1)) begin
      // Body of the frame; a header value here is plain data.
      fb_we               = 1'b1;
      byte_sum_next       = byte_sum + rx_byte;
      frame_position_next = frame_position + POS_W'(1);
    end else begin
      // Checksum byte: judge the frame in priority order.
      frame_position_next = '0;
      byte_sum_next       = '0;
      if (frame_bytes[0] != HEADER_BYTE) begin
        ev = EV_BAD_HEADER;
      end else if (byte_sum != rx_byte) begin
        cnt_checksum_next = cnt_checksum + CNT_W'(1);
        ev                = EV_CHECKSUM;
      end else if (frame_strength < min_strength) begin
        cnt_weak_next = cnt_weak + CNT_W'(1);
        ev            = EV_WEAK;
      end else begin
        held_distance_next    = frame_distance;
        held_strength_next    = frame_strength;
        held_temperature_next = frame_temperature;
        cnt_good_next         = cnt_good + CNT_W'(1);
        ev                    = EV_VALID;
      end
    end
  end

  always_comb begin
    res_next.event_res       = ev;
    res_next.distance_cm     = held_distance_next;
    res_next.signal_strength = held_strength_next;
    res_next.temp_centi      = held_temperature_next;
    res_next.reading_valid   = (held_distance_next != invalid_distance);
    res_next.good_frames     = cnt_good_next;
    res_next.checksum_errors = cnt_checksum_next;
    res_next.weak_frames     = cnt_weak_next;
    res_next.dropped_bytes   = cnt_dropped_next;
  end

  // Parse state, held readings and counters advance on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position   <= '0;
      byte_sum         <= '0;
      held_distance    <= INVALID_DISTANCE_RST;
      held_strength    <= '0;
      held_temperature <= '0;
      cnt_good         <= '0;
      cnt_checksum     <= '0;
      cnt_weak         <= '0;
      cnt_dropped      <= '0;
    end else if (in_fire) begin
      frame_position   <= frame_position_next;
      byte_sum         <= byte_sum_next;
      held_distance    <= held_distance_next;
      held_strength    <= held_strength_next;
      held_temperature <= held_temperature_next;
      cnt_good         <= cnt_good_next;
      cnt_checksum     <= cnt_checksum_next;
      cnt_weak         <= cnt_weak_next;
      cnt_dropped      <= cnt_dropped_next;
    end
  end

  // Frame byte store has no reset: every entry is written before the
  // checksum byte reads it.
  always_ff @(posedge clk) begin
    if (in_fire && fb_we) begin
      frame_bytes[fb_wr_idx] <= rx_byte;
    end
  end

  // Output register plus skid register. When the output register is free,
  // it takes the skid entry if there is one, else the new result. When it
  // is held, a new result parks in the skid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || in_fire;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (in_fire) begin
        out_res <= res_next;
      end
    end else if (in_fire) begin
      skid_res <= res_next;
    end
  end

  assign event_res       = out_res.event_res;
  assign distance_cm     = out_res.distance_cm;
  assign signal_strength = out_res.signal_strength;
  assign temp_centi      = out_res.temp_centi;
  assign reading_valid   = out_res.reading_valid;
  assign good_frames     = out_res.good_frames;
  assign checksum_errors = out_res.checksum_errors;
  assign weak_frames     = out_res.weak_frames;
  assign dropped_bytes   = out_res.dropped_bytes;

endmodule

// File: rtl/lfp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar frame parser checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module lfp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              cfg_we,
  input logic [lfp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input logic [lfp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [7:0]                        rx_byte,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [2:0]                        event_res,
  input logic signed [15:0]                distance_cm,
  input logic [15:0]                       signal_strength,
  input logic [15:0]                       temp_centi,
  input logic                              reading_valid,
  input logic [lfp_pkg::CNT_W-1:0]         good_frames,
  input logic [lfp_pkg::CNT_W-1:0]         checksum_errors,
  input logic [lfp_pkg::CNT_W-1:0]         weak_frames,
  input logic [lfp_pkg::CNT_W-1:0]         dropped_bytes
);
  import lfp_pkg::*;

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // A dropped byte follows the previous result with exactly one more drop.
  a_drop_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) ##1 (out_valid && event_res == EV_DROPPED)
    |-> dropped_bytes == $past(dropped_bytes) + CNT_W'(1))
    else $error("dropped byte count did not advance by one");

  // A byte taken into a frame leaves every counter and the distance unchanged.
  a_in_frame_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) ##1 (out_valid && event_res == EV_IN_FRAME)
    |-> $stable(good_frames) && $stable(checksum_errors) && $stable(weak_frames)
        && $stable(dropped_bytes) && $stable(distance_cm))
    else $error("in-frame byte changed a counter or reading");

  // A valid frame adds one good frame.
  a_good_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) ##1 (out_valid && event_res == EV_VALID)
    |-> good_frames == $past(good_frames) + CNT_W'(1))
    else $error("good frame count did not advance by one");

endmodule

bind lidar_frame_parser_unit lfp_checker u_lfp_checker (.*);
